// ===== hw/rtl/dpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpa_pkg;

	// Field widths of one beat
	localparam int BTN_W  = 4;
	localparam int KIND_W = 3;
	localparam int DUR_W  = 16;
	localparam int TAG_W  = 32;
	localparam int WIN_W  = 16;
	localparam int OUT_W  = 24;

	// Event kinds that the arbiter acts on
	localparam logic [KIND_W-1:0] KIND_SHORT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd5;

	// Register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 1'd1;

	localparam logic [WIN_W-1:0] WINDOW_RESET  = 16'd300;
	localparam logic [BTN_W-1:0] CONFIRM_RESET = 4'd0;

	// One emitted event
	typedef struct packed {
		logic              last;
		logic [DUR_W-1:0]  duration;
		logic [KIND_W-1:0] kind;
		logic [BTN_W-1:0]  button;
	} res_t;

	// Results of one item, first result in r0
	typedef struct packed {
		logic [1:0] count;
		res_t       r1;
		res_t       r0;
	} res_set_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpa_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpa_decide
	import dpa_pkg::*;
#(
	parameter int TIME_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire logic                 func,
	input  wire logic [BTN_W-1:0]     event_button,
	input  wire logic [KIND_W-1:0]    event_kind,
	input  wire logic [DUR_W-1:0]     event_duration,
	input  wire logic [TIME_BITS-1:0] event_time,
	input  wire logic [TAG_W-1:0]     context_tag,
	input  wire logic [WIN_W-1:0]     window_ms,
	input  wire logic [BTN_W-1:0]     confirm_button,
	output res_set_t                  results
);

	logic                 pend_q;
	logic [DUR_W-1:0]     pend_len_q;
	logic [TIME_BITS-1:0] pend_since_q;
	logic [TAG_W-1:0]     pend_tag_q;
	logic [BTN_W-1:0]     pend_btn_q;

	logic [TIME_BITS-1:0] diff;
	logic                 in_window;
	logic                 same_tag;
	logic                 flush_emit;
	logic                 pend_after;
	logic                 is_conf;
	logic                 release_pend;
	logic                 second;
	logic                 start_pend;
	logic                 pend_next;
	res_t                 pend_res;
	res_t                 evt_res;

	// Signed age of the pending single; negative counts as inside the window
	assign diff      = event_time - pend_since_q;
	assign in_window = diff[TIME_BITS-1] || (diff < TIME_BITS'(window_ms));
	assign same_tag  = (context_tag == pend_tag_q);

	// Release a due single; drop it on a context change
	assign flush_emit = pend_q && same_tag && !in_window;
	assign pend_after = pend_q && same_tag && in_window;

	assign is_conf = (event_button == confirm_button) && (event_kind == KIND_SHORT);

	// Release a due single, or one still inside the window when another button comes
	assign release_pend = flush_emit ||
		(func && !is_conf && pend_after && (event_button != confirm_button));
	assign second     = func && (!is_conf || pend_after);
	assign start_pend = func && is_conf && !pend_after;

	always_comb begin
		if (func && is_conf) begin
			pend_next = !pend_after;
		end else if (func) begin
			pend_next = pend_after && (event_button == confirm_button);
		end else begin
			pend_next = pend_after;
		end
	end

	// Build the result beats
	always_comb begin
		pend_res.button   = pend_btn_q;
		pend_res.kind     = KIND_SHORT;
		pend_res.duration = pend_len_q;
		pend_res.last     = !second;

		evt_res.duration = event_duration;
		evt_res.last     = 1'b1;
		if (is_conf) begin
			evt_res.button = confirm_button;
			evt_res.kind   = KIND_DOUBLE;
		end else begin
			evt_res.button = event_button;
			evt_res.kind   = event_kind;
		end

		results.count = {1'b0, release_pend} + {1'b0, second};
		results.r0    = release_pend ? pend_res : evt_res;
		results.r1    = evt_res;
	end

	// Pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (fire) begin
			pend_q <= pend_next;
		end
	end

	// Capture a new pending single
	always_ff @(posedge clk) begin
		if (fire && start_pend) begin
			pend_len_q   <= event_duration;
			pend_since_q <= event_time;
			pend_tag_q   <= context_tag;
			pend_btn_q   <= event_button;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dpa_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpa_outq
	import dpa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  res_set_t              results,
	output logic                  room,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	logic [1:0] count_q;
	res_t       head_q;
	res_t       tail_q;
	logic       pop;

	assign pop  = m_axis_tvalid && m_axis_tready;
	// Take a new item only when the buffer is empty or drains this cycle
	assign room = (count_q == 2'd0) || ((count_q == 2'd1) && pop);

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = {{(OUT_W - DUR_W - KIND_W - BTN_W){1'b0}},
		head_q.duration, head_q.kind, head_q.button};
	assign m_axis_tlast  = head_q.last;

	// Beat count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push) begin
			count_q <= results.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Load both beats, or advance the second into the head
	always_ff @(posedge clk) begin
		if (push) begin
			head_q <= results.r0;
			tail_q <= results.r1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/confirm_double_press_arbiter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Confirm double-press arbiter. Input beats are ticks (tuser 0) or button
// events (tuser 1); a short confirm press is held back and either merged with
// a second short confirm into a double press, released as a short press once
// the window has run out or another button is seen, or dropped on a context
// change. An input beat is registered in stage one, then moved into the result
// buffer, which drives its first result out. One input beat is accepted per
// cycle while the result side keeps up; a beat with two results holds the
// input back while both leave through the one output channel. The user must
// write configuration while the block is idle; the block does not enforce it.
module confirm_double_press_arbiter_top
	import dpa_pkg::*;
#(
	parameter int TIME_BITS = 40
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [WIN_W-1:0]      cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// event_button, event_kind, event_duration, event_time, context_tag, pad
	input  wire logic [((BTN_W + KIND_W + DUR_W + TIME_BITS + TAG_W + 7) / 8) * 8 - 1:0]
		s_axis_tdata,
	// func
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// out_button, out_kind, out_duration, pad
	output logic [OUT_W-1:0]           m_axis_tdata,
	output logic                       m_axis_tlast
);

	localparam int KIND_LO = BTN_W;
	localparam int DUR_LO  = KIND_LO + KIND_W;
	localparam int TIME_LO = DUR_LO + DUR_W;
	localparam int TAG_LO  = TIME_LO + TIME_BITS;

	logic [WIN_W-1:0]     window_q;
	logic [BTN_W-1:0]     confirm_q;

	logic                 valid_s1;
	logic                 func_s1;
	logic [BTN_W-1:0]     button_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [DUR_W-1:0]     dur_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [TAG_W-1:0]     tag_s1;

	logic                 room;
	logic                 fire;
	logic                 accept;
	res_set_t             results;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			confirm_q <= CONFIRM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW:  window_q  <= cfg_data;
				CFG_CONFIRM: confirm_q <= cfg_data[BTN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage one moves into the result buffer when it has room
	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= s_axis_tuser;
			button_s1 <= s_axis_tdata[KIND_LO-1:0];
			kind_s1   <= s_axis_tdata[DUR_LO-1:KIND_LO];
			dur_s1    <= s_axis_tdata[TIME_LO-1:DUR_LO];
			time_s1   <= s_axis_tdata[TAG_LO-1:TIME_LO];
			tag_s1    <= s_axis_tdata[TAG_LO+TAG_W-1:TAG_LO];
		end
	end

	dpa_decide #(
		.TIME_BITS(TIME_BITS)
	) u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.func           (func_s1),
		.event_button   (button_s1),
		.event_kind     (kind_s1),
		.event_duration (dur_s1),
		.event_time     (time_s1),
		.context_tag    (tag_s1),
		.window_ms      (window_q),
		.confirm_button (confirm_q),
		.results        (results)
	);

	dpa_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (fire),
		.results       (results),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/dpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpa_checker
	import dpa_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             m_axis_tlast
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("result beat changed while stalled");

	// The second beat of an item follows right after the first
	a_pair_close: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("second result beat missing");

	// A first of two beats is always a released short press
	a_first_short: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
		(m_axis_tdata[BTN_W+KIND_W-1:BTN_W] == KIND_SHORT))
		else $error("non-final beat is not a short press");

	// No result beat once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result beat during reset");

endmodule

bind confirm_double_press_arbiter_top dpa_checker u_dpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import dpa_pkg::*;

	localparam int STAMP_W = 40;
	localparam int IN_W = ((BTN_W + KIND_W + DUR_W + STAMP_W + TAG_W + 7) / 8) * 8;

	// Bit offsets inside the input tdata
	localparam int KIND_LO  = BTN_W;
	localparam int DUR_LO   = KIND_LO + KIND_W;
	localparam int STAMP_LO = DUR_LO + DUR_W;
	localparam int TAG_LO   = STAMP_LO + STAMP_W;

	// Event kinds not named in the package
	localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LONG    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNDEF6  = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNDEF7  = 3'd7;

	localparam bit FUNC_TICK  = 1'b0;
	localparam bit FUNC_EVENT = 1'b1;

	localparam int PREDICTED       = -1;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 206;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam res_t NO_RESULT     = '0;

	typedef struct {
		bit                 func;
		logic [BTN_W-1:0]   button;
		logic [KIND_W-1:0]  kind;
		logic [DUR_W-1:0]   dur;
		logic [STAMP_W-1:0] stamp;
		logic [TAG_W-1:0]   tag;
	} press_item_t;

	typedef struct {
		press_item_t item;
		int          n_exp;
		res_t        first;
		res_t        second;
	} stim_row_t;

	logic                 clk = 1'b1;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
	logic [WIN_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b1;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 m_axis_tlast;

	confirm_double_press_arbiter_top #(
		.TIME_BITS(STAMP_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Predictor state: the held single press and the register copies
	bit                 held = 1'b0;
	logic [DUR_W-1:0]   held_dur = '0;
	logic [STAMP_W-1:0] held_since = '0;
	logic [TAG_W-1:0]   held_tag = '0;
	logic [BTN_W-1:0]   held_button = '0;
	logic [WIN_W-1:0]   win_ms = WINDOW_RESET;
	logic [BTN_W-1:0]   confirm_id = CONFIRM_RESET;
	res_t               step_out [2];

	res_t expected_events [$];
	int   mismatches = 0;
	int   results_seen = 0;
	int   stuck_cycles = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;

	// Expectation typed into a directed row, taken at acceptance
	int   typed_count = PREDICTED;
	res_t typed_first = '0;
	res_t typed_second = '0;

	int phase_win [PHASES]     = '{1, 65535, 0, 20, 100, 5, 1000, 50};
	int phase_confirm [PHASES] = '{15, 0, 7, 3, 15, 1, 9, 0};
	int phase_idle [PHASES]    = '{0, 88, 0, 38, 0, 88, 0, 38};
	int phase_stall [PHASES]   = '{0, 0, 88, 38, 0, 0, 88, 38};

	function automatic res_t outcome(logic [BTN_W-1:0] btn, logic [KIND_W-1:0] kind,
			logic [DUR_W-1:0] dur, bit last);
		return '{last: last, duration: dur, kind: kind, button: btn};
	endfunction

	function automatic stim_row_t stim(bit func, logic [BTN_W-1:0] btn,
			logic [KIND_W-1:0] kind, logic [DUR_W-1:0] dur, logic [STAMP_W-1:0] stamp,
			logic [TAG_W-1:0] tag, int n_exp, res_t first, res_t second);
		stim_row_t r;
		r.item = '{func: func, button: btn, kind: kind, dur: dur, stamp: stamp, tag: tag};
		r.n_exp = n_exp;
		r.first = first;
		r.second = second;
		return r;
	endfunction

	function automatic void drop_held();
		held = 1'b0;
		held_dur = '0;
		held_since = '0;
		held_tag = '0;
		held_button = '0;
	endfunction

	// Signed distance from the held press; negative always counts as inside
	function automatic bit within_window(logic [STAMP_W-1:0] now, bit or_equal);
		logic [STAMP_W-1:0] d;
		d = now - held_since;
		if (d[STAMP_W-1])
			return 1'b1;
		return or_equal ? (d <= STAMP_W'(win_ms)) : (d < STAMP_W'(win_ms));
	endfunction

	// Work out the events one item emits into step_out; return their count
	function automatic int arbitrate(press_item_t it);
		int n;
		n = 0;
		// release or drop a held single before anything else
		if (held) begin
			if (it.tag != held_tag) begin
				drop_held();
			end else if (!within_window(it.stamp, 1'b0)) begin
				step_out[n] = outcome(held_button, KIND_SHORT, held_dur, 1'b0);
				n++;
				drop_held();
			end
		end
		if (it.func == FUNC_EVENT) begin
			if (it.button == confirm_id && it.kind == KIND_SHORT) begin
				if (held && it.tag == held_tag && within_window(it.stamp, 1'b1)) begin
					drop_held();
					step_out[n] = outcome(confirm_id, KIND_DOUBLE, it.dur, 1'b1);
					return n + 1;
				end
				held = 1'b1;
				held_dur = it.dur;
				held_since = it.stamp;
				held_tag = it.tag;
				held_button = it.button;
			end else begin
				if (held && it.button != confirm_id) begin
					if (it.tag == held_tag) begin
						step_out[n] = outcome(held_button, KIND_SHORT, held_dur, 1'b0);
						n++;
					end
					drop_held();
				end
				step_out[n] = outcome(it.button, it.kind, it.dur, 1'b0);
				n++;
			end
		end
		if (n > 0)
			step_out[n-1].last = 1'b1;
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = WIN_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_WINDOW)
			win_ms = WIN_W'(value);
		else
			confirm_id = BTN_W'(value);
	endtask

	// Present one beat after a random gap and hold it until accepted
	task automatic drive_item(input press_item_t it, input int n_exp, input res_t first,
			input res_t second);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = IN_W'({it.tag, it.stamp, it.dur, it.kind, it.button});
		s_axis_tuser = it.func;
		typed_count = n_exp;
		typed_first = first;
		typed_second = second;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold the input until every expected event is out, then let the block go quiet
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Random stall on the result side
	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= stall_pct);

	// Predict on input beats, check output beats, watch for a hang
	always @(posedge clk) begin : scoreboard
		press_item_t it;
		res_t        got;
		res_t        want;
		int          n;
		if (s_axis_tvalid && s_axis_tready) begin
			it.func = s_axis_tuser;
			it.button = s_axis_tdata[0 +: BTN_W];
			it.kind = s_axis_tdata[KIND_LO +: KIND_W];
			it.dur = s_axis_tdata[DUR_LO +: DUR_W];
			it.stamp = s_axis_tdata[STAMP_LO +: STAMP_W];
			it.tag = s_axis_tdata[TAG_LO +: TAG_W];
			n = arbitrate(it);
			if (typed_count == PREDICTED) begin
				for (int i = 0; i < n; i++)
					expected_events.push_back(step_out[i]);
			end else begin
				if (typed_count > 0)
					expected_events.push_back(typed_first);
				if (typed_count > 1)
					expected_events.push_back(typed_second);
			end
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{last: m_axis_tlast, duration: m_axis_tdata[DUR_LO +: DUR_W],
				kind: m_axis_tdata[KIND_LO +: KIND_W], button: m_axis_tdata[0 +: BTN_W]};
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected beat button %0d kind %0d dur %0d",
					got.button, got.kind, got.duration));
			end else begin
				want = expected_events.pop_front();
				if (got.button !== want.button)
					report_mismatch($sformatf("button %0d, want %0d", got.button, want.button));
				if (got.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
				if (got.duration !== want.duration)
					report_mismatch($sformatf("duration %0d, want %0d",
						got.duration, want.duration));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
			end
			results_seen++;
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t          directed_rows [25];
		press_item_t        it;
		logic [STAMP_W-1:0] walk_stamp;
		logic [TAG_W-1:0]   walk_tag;
		int                 r;

		// Reset-time settings: window 300, confirm button 0
		directed_rows = '{
			stim(FUNC_TICK, 0, KIND_PRESS, 0, 0, 0, 0, NO_RESULT, NO_RESULT),
			stim(FUNC_EVENT, 3, KIND_PRESS, 0, 0, 0, 1,
				outcome(3, KIND_PRESS, 0, 1'b1), NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_SHORT, 100, 100, 1, 0, NO_RESULT, NO_RESULT),
			// second short one just inside the window
			stim(FUNC_EVENT, 0, KIND_SHORT, 16'hFFFF, 399, 1, 1,
				outcome(0, KIND_DOUBLE, 16'hFFFF, 1'b1), NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_SHORT, 50, 1000, 1, 0, NO_RESULT, NO_RESULT),
			// exactly at the window: release the first, hold the second
			stim(FUNC_EVENT, 0, KIND_SHORT, 60, 1300, 1, 1,
				outcome(0, KIND_SHORT, 50, 1'b1), NO_RESULT),
			stim(FUNC_TICK, 0, KIND_PRESS, 0, 1599, 1, 0, NO_RESULT, NO_RESULT),
			stim(FUNC_TICK, 0, KIND_PRESS, 0, 1600, 1, 1,
				outcome(0, KIND_SHORT, 60, 1'b1), NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_SHORT, 7, 2000, 1, 0, NO_RESULT, NO_RESULT),
			// context change drops the held press silently
			stim(FUNC_TICK, 0, KIND_PRESS, 0, 2001, 2, 0, NO_RESULT, NO_RESULT),
			stim(FUNC_TICK, 0, KIND_PRESS, 0, 5000, 2, 0, NO_RESULT, NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_SHORT, 8, 3000, 5, 0, NO_RESULT, NO_RESULT),
			// other button: release the held single, then pass through
			stim(FUNC_EVENT, 9, KIND_LONG, 16'h1234, 3010, 5, 2,
				outcome(0, KIND_SHORT, 8, 1'b0), outcome(9, KIND_LONG, 16'h1234, 1'b1)),
			stim(FUNC_EVENT, 0, KIND_SHORT, 9, 4000, 5, 0, NO_RESULT, NO_RESULT),
			stim(FUNC_EVENT, 9, KIND_HOLD, 16'hABCD, 4001, 6, 1,
				outcome(9, KIND_HOLD, 16'hABCD, 1'b1), NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_SHORT, 10, 5000, 7, 0, NO_RESULT, NO_RESULT),
			// non-short confirm events pass and keep the held press
			stim(FUNC_EVENT, 0, KIND_PRESS, 11, 5001, 7, 1,
				outcome(0, KIND_PRESS, 11, 1'b1), NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_RELEASE, 12, 5002, 7, 1,
				outcome(0, KIND_RELEASE, 12, 1'b1), NO_RESULT),
			// earlier timestamp still counts as inside the window
			stim(FUNC_EVENT, 0, KIND_SHORT, 13, 4000, 7, 1,
				outcome(0, KIND_DOUBLE, 13, 1'b1), NO_RESULT),
			stim(FUNC_EVENT, 15, KIND_UNDEF7, 16'hFFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1,
				outcome(15, KIND_UNDEF7, 16'hFFFF, 1'b1), NO_RESULT),
			// timestamp wrap between two short presses
			stim(FUNC_EVENT, 0, KIND_SHORT, 14, 40'hFF_FFFF_FF9C, 32'hFFFF_FFFF, 0,
				NO_RESULT, NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_SHORT, 15, 50, 32'hFFFF_FFFF, PREDICTED,
				NO_RESULT, NO_RESULT),
			stim(FUNC_EVENT, 14, KIND_UNDEF6, 0, 40'hFF_FFFF_FFFF, 0, PREDICTED,
				NO_RESULT, NO_RESULT),
			stim(FUNC_EVENT, 0, KIND_DOUBLE, 1, 0, 0, PREDICTED, NO_RESULT, NO_RESULT),
			stim(FUNC_TICK, 15, KIND_UNDEF7, 16'hFFFF, 40'h55_5555_5555, 32'hAAAA_AAAA,
				PREDICTED, NO_RESULT, NO_RESULT)
		};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			drive_item(directed_rows[i].item, directed_rows[i].n_exp,
				directed_rows[i].first, directed_rows[i].second);
		settle();

		walk_stamp = '0;
		walk_tag = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_WINDOW, phase_win[ph]);
			write_reg(CFG_CONFIRM, phase_confirm[ph]);
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// pause the input once per phase until the output catches up
				if (k == ITEMS_PER_PHASE / 2) begin
					s_axis_tvalid = 1'b0;
					while (expected_events.size() != 0)
						@(posedge clk);
					@(negedge clk);
				end

				// advance time mostly around the window, sometimes far or backward
				r = $urandom_range(99);
				if (held && r < 15)
					walk_stamp = held_since + STAMP_W'(win_ms)
						+ STAMP_W'($urandom_range(2)) - STAMP_W'(1);
				else if (r < 80)
					walk_stamp += STAMP_W'($urandom_range(2 * int'(win_ms) + 2));
				else if (r < 88)
					walk_stamp += STAMP_W'($urandom);
				else if (r < 95)
					walk_stamp -= STAMP_W'($urandom_range(2 * int'(win_ms) + 2));
				else
					walk_stamp = {8'($urandom), 32'($urandom)};

				// keep the context mostly steady
				r = $urandom_range(99);
				if (r >= 97)
					walk_tag = $urandom;
				else if (r >= 85)
					walk_tag = TAG_W'($urandom_range(3));

				it.stamp = walk_stamp;
				it.tag = walk_tag;
				it.func = ($urandom_range(99) < 45) ? FUNC_TICK : FUNC_EVENT;
				it.button = BTN_W'($urandom);
				it.kind = KIND_W'($urandom);
				it.dur = DUR_W'($urandom);
				if (it.func == FUNC_EVENT) begin
					r = $urandom_range(99);
					if (r < 55) begin
						it.button = confirm_id;
						it.kind = KIND_SHORT;
					end else if (r < 75) begin
						while (it.button == confirm_id)
							it.button = BTN_W'($urandom);
					end else if (r < 90) begin
						it.button = confirm_id;
					end
				end
				drive_item(it, PREDICTED, NO_RESULT, NO_RESULT);
			end
			settle();
		end

		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d expected events never came",
				expected_events.size()));
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dpa_pkg.sv
hw/rtl/dpa_decide.sv
hw/rtl/dpa_outq.sv
hw/rtl/confirm_double_press_arbiter_top.sv
hw/rtl/dpa_checker.sv
bench/testbench.sv
